// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file of the keystream cipher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DNK_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("dnk assertion failed");

// consequence that must hold in the cycle after the antecedent
`define DNK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dnk assertion failed");

`endif

// ===== hw/rtl/dnk_pkg.sv =====
// shared constants and types of the dual nfsr keystream cipher
`timescale 1ns / 1ps

package dnk_pkg;

    localparam int KEY_LEN    = 56;
    localparam int LOAD_STEPS = 122;
    localparam int DIFF_STEPS = 128;
    localparam int ENC_STEPS  = 8;
    localparam int KEY_TAP    = 120 - KEY_LEN;
    localparam int SHORT_LEN  = 31;
    localparam int LONG_LEN   = 90;
    localparam int CNT_W      = 7;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIFF,
        S_ENC,
        S_DONE
    } t_state;

    // kind of register step
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_DIFF,
        OP_ENC
    } t_step_op;

    // per-cycle step control from sequencer to datapath
    typedef struct packed {
        logic     step;
        t_step_op op;
        logic     key_sel;
    } t_step_ctl;

endpackage

// ===== hw/rtl/dnk_nfsr.sv =====
// short and long nonlinear feedback registers, one step per cycle while step is set
`timescale 1ns / 1ps

module dnk_nfsr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dnk_pkg::t_step_ctl i_ctl,
    input  logic               i_key_bit,
    output logic               o_ks_bit
);
    import dnk_pkg::*;

    logic [SHORT_LEN-1:0] r_s, n_s;
    logic [LONG_LEN-1:0]  r_b, n_b;
    logic                 w_nx, w_ny, w_na;
    logic                 w_s_top, w_b_top;

    // short register feedback
    always_comb begin
        w_nx = r_s[0] ^ r_s[2] ^ r_s[5] ^ r_s[6] ^ r_s[15] ^ r_s[17] ^ r_s[18]
             ^ r_s[20] ^ r_s[25]
             ^ (r_s[8] & r_s[18]) ^ (r_s[8] & r_s[20]) ^ (r_s[12] & r_s[21])
             ^ (r_s[14] & r_s[19]) ^ (r_s[17] & r_s[21]) ^ (r_s[20] & r_s[22])
             ^ (r_s[4] & r_s[12] & r_s[22]) ^ (r_s[4] & r_s[19] & r_s[22])
             ^ (r_s[7] & r_s[20] & r_s[21]) ^ (r_s[8] & r_s[18] & r_s[22])
             ^ (r_s[8] & r_s[20] & r_s[22]) ^ (r_s[12] & r_s[19] & r_s[22])
             ^ (r_s[20] & r_s[21] & r_s[22])
             ^ (r_s[4] & r_s[7] & r_s[12] & r_s[21])
             ^ (r_s[4] & r_s[7] & r_s[19] & r_s[21])
             ^ (r_s[4] & r_s[12] & r_s[21] & r_s[22])
             ^ (r_s[4] & r_s[19] & r_s[21] & r_s[22])
             ^ (r_s[7] & r_s[8] & r_s[18] & r_s[21])
             ^ (r_s[7] & r_s[8] & r_s[20] & r_s[21])
             ^ (r_s[7] & r_s[12] & r_s[19] & r_s[21])
             ^ (r_s[8] & r_s[18] & r_s[21] & r_s[22])
             ^ (r_s[8] & r_s[20] & r_s[21] & r_s[22])
             ^ (r_s[12] & r_s[19] & r_s[21] & r_s[22]);
    end

    // long register feedback
    always_comb begin
        w_ny = r_s[0] ^ r_b[0] ^ r_b[24] ^ r_b[49] ^ r_b[79] ^ r_b[84]
             ^ (r_b[3] & r_b[59]) ^ (r_b[10] & r_b[12]) ^ (r_b[15] & r_b[16])
             ^ (r_b[25] & r_b[53]) ^ (r_b[35] & r_b[42]) ^ (r_b[55] & r_b[58])
             ^ (r_b[60] & r_b[74])
             ^ (r_b[20] & r_b[22] & r_b[23]) ^ (r_b[62] & r_b[68] & r_b[72])
             ^ (r_b[77] & r_b[80] & r_b[81] & r_b[83]);
    end

    // keystream output bit
    always_comb begin
        w_na = r_b[5] ^ r_b[7] ^ r_b[11] ^ r_b[30] ^ r_b[40] ^ r_b[45] ^ r_b[54]
             ^ r_b[71]
             ^ (r_b[4] & r_b[21]) ^ (r_b[9] & r_b[52]) ^ (r_b[18] & r_b[37])
             ^ (r_b[44] & r_b[76]) ^ (r_b[8] & r_b[82])
             ^ (r_b[34] & r_b[67] & r_b[73])
             ^ (r_b[2] & r_b[28] & r_b[41] & r_b[65])
             ^ (r_b[13] & r_b[29] & r_b[50] & r_b[64] & r_b[75])
             ^ (r_b[6] & r_b[14] & r_b[26] & r_b[32] & r_b[47] & r_b[61])
             ^ (r_b[1] & r_b[19] & r_b[27] & r_b[43] & r_b[57] & r_b[66] & r_b[78])
             ^ r_s[23] ^ (r_s[3] & r_s[16]) ^ (r_s[9] & r_s[13] & r_b[48])
             ^ (r_s[1] & r_s[24] & r_b[38] & r_b[63]);
    end

    // new top bits by step kind
    always_comb begin
        case (i_ctl.op)
            OP_LOAD: begin
                w_s_top = i_ctl.key_sel ? i_key_bit : r_b[KEY_TAP];
                w_b_top = r_s[0];
            end
            OP_DIFF: begin
                w_s_top = w_nx ^ w_na;
                w_b_top = w_ny ^ w_na;
            end
            OP_ENC: begin
                w_s_top = w_nx;
                w_b_top = w_ny;
            end
            default: begin
                w_s_top = w_nx;
                w_b_top = w_ny;
            end
        endcase
        n_s = {w_s_top, r_s[SHORT_LEN-1:1]};
        n_b = {w_b_top, r_b[LONG_LEN-1:1]};
    end

    // register shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
            r_b <= '0;
        end else if (i_ctl.step) begin
            r_s <= n_s;
            r_b <= n_b;
        end
    end

    assign o_ks_bit = w_na;

endmodule

// ===== hw/rtl/dnk_ctrl.sv =====
// step sequencer for load, diffusion and encrypt runs
`timescale 1ns / 1ps

module dnk_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_req,
    input  logic               i_mode,
    input  logic               i_out_free,
    output dnk_pkg::t_step_ctl o_ctl,
    output logic               o_busy,
    output logic               o_finish
);
    import dnk_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // next state and step control
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        o_ctl.step    = 1'b0;
        o_ctl.op      = OP_ENC;
        o_ctl.key_sel = 1'b0;
        o_finish      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_req) begin
                    n_count = '0;
                    n_state = i_mode ? S_ENC : S_LOAD;
                end
            end
            S_LOAD: begin
                o_ctl.step    = 1'b1;
                o_ctl.op      = OP_LOAD;
                o_ctl.key_sel = (r_count < CNT_W'(KEY_LEN));
                if (r_count == CNT_W'(LOAD_STEPS - 1)) begin
                    n_count = '0;
                    n_state = S_DIFF;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            S_DIFF: begin
                o_ctl.step = 1'b1;
                o_ctl.op   = OP_DIFF;
                if (r_count == CNT_W'(DIFF_STEPS - 1)) begin
                    n_count = '0;
                    n_state = S_DONE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            S_ENC: begin
                o_ctl.step = 1'b1;
                o_ctl.op   = OP_ENC;
                if (r_count == CNT_W'(ENC_STEPS - 1)) begin
                    n_count = '0;
                    n_state = S_DONE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_finish = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_count = '0;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/dual_nfsr_keystream_cipher.sv =====
// top level of the dual nfsr keystream cipher
`timescale 1ns / 1ps
//
// Stream cipher with a 31-bit and a 90-bit nonlinear feedback register.
// Configuration: i_cfg_we with i_cfg_data writes the 56-bit key; it is used
// only when an init request is processed. Write it while the block is idle.
// Input channel: i_in_valid / o_in_stall carry i_mode and i_data_byte.
// mode 0 loads the key (122 steps) and diffuses it (128 steps); mode 1
// runs 8 steps and returns i_data_byte XOR the keystream byte, first bit MSB.
// Output channel: o_out_valid / i_out_stall carry o_result_byte and
// o_init_done; one result per request, held in an output register.
// Both registers step once per cycle while a run is in progress. An encrypt
// request steps in S_ENC, an init request in S_LOAD and then S_DIFF; each run
// hands its result over in S_DONE, and the block returns to S_IDLE before
// it takes the next request. One request is in work at a time; the next
// is accepted while the previous result still waits in the output register.
// A stalled receiver holds the result; a finished run then waits until the
// output register frees before it hands over its result.
// Reset clears both feedback registers, the key, sequencer and output valid.
//
module dual_nfsr_keystream_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [55:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_result_byte,
    output logic        o_init_done
);
    import dnk_pkg::*;

    logic [KEY_LEN-1:0] r_cipher_key;
    logic [KEY_LEN-1:0] r_key_sr;
    logic [7:0]         r_data;
    logic               r_mode;
    logic               r_out_valid;
    logic [7:0]         r_result;
    logic               r_init_done;
    logic               w_in_req;
    logic               w_out_free;
    logic               w_busy;
    logic               w_finish;
    logic               w_ks_bit;
    t_step_ctl          w_ctl;

    assign w_in_req   = i_in_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (i_cfg_we) begin
            r_cipher_key <= i_cfg_data;
        end
    end

    // key bit shifter and data byte rotator
    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_mode <= i_mode;
            r_data <= i_data_byte;
            if (!i_mode) begin
                r_key_sr <= r_cipher_key;
            end
        end else if (w_ctl.step) begin
            if (w_ctl.op == OP_LOAD && w_ctl.key_sel) begin
                r_key_sr <= {1'b0, r_key_sr[KEY_LEN-1:1]};
            end
            if (w_ctl.op == OP_ENC) begin
                r_data <= {r_data[6:0], r_data[7] ^ w_ks_bit};
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_result    <= r_mode ? r_data : 8'd0;
            r_init_done <= !r_mode;
        end
    end

    dnk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_req   (w_in_req),
        .i_mode     (i_mode),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_busy     (w_busy),
        .o_finish   (w_finish)
    );

    dnk_nfsr u_nfsr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_key_bit (r_key_sr[0]),
        .o_ks_bit  (w_ks_bit)
    );

    assign o_in_stall    = w_busy;
    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_result;
    assign o_init_done   = r_init_done;

    // checks
`include "assert_macros.svh"
    `DNK_ASSERT_NEXT(a_busy_after_req, w_in_req, o_in_stall)
    `DNK_ASSERT_ALWAYS(a_init_zero_byte, !(o_out_valid && o_init_done) || o_result_byte == 8'd0)
    `DNK_ASSERT_ALWAYS(a_no_overwrite, !(w_finish && r_out_valid && i_out_stall))
    `DNK_ASSERT_ALWAYS(a_step_only_busy, !w_ctl.step || w_busy)

endmodule
